@@ hdl/yuyv_pkg.sv @@
// Shared types and constants for the YUYV to RGB24 converter.
// No dependencies.
package yuyv_pkg;

    localparam int PIX_W   = 8;
    localparam int DELTA_W = 10;
    localparam int SUM_W   = 11;

    localparam logic signed [8:0] CHROMA_BIAS  = 9'sd128;
    localparam logic signed [8:0] COEF_RED_V   = 9'sd104;
    localparam logic signed [8:0] COEF_GREEN_U = 9'sd89;
    localparam logic signed [8:0] COEF_GREEN_V = 9'sd183;
    localparam logic signed [8:0] COEF_BLUE_U  = 9'sd199;
    localparam logic [PIX_W-1:0]  CHANNEL_MAX  = 8'd255;

    typedef struct packed {
        logic signed [DELTA_W-1:0] dr;
        logic signed [DELTA_W-1:0] dg;
        logic signed [DELTA_W-1:0] db;
    } t_chroma_delta;

    typedef struct packed {
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] r;
    } t_rgb;

endpackage

@@ hdl/yuyv_chroma.sv @@
// Shared chroma stage: per-channel color offsets from U and V, registered.
// Depends on yuyv_pkg.
module yuyv_chroma
    import yuyv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [PIX_W-1:0]    i_cb,
    input  logic [PIX_W-1:0]    i_cr,
    output t_chroma_delta       o_delta
);

    logic signed [8:0]         w_u;
    logic signed [8:0]         w_v;
    logic signed [17:0]        w_p_rv;
    logic signed [17:0]        w_p_gu;
    logic signed [17:0]        w_p_gv;
    logic signed [17:0]        w_p_bu;
    logic signed [17:0]        w_s_rv;
    logic signed [17:0]        w_s_gu;
    logic signed [17:0]        w_s_gv;
    logic signed [17:0]        w_s_bu;
    t_chroma_delta             n_delta;
    t_chroma_delta             r_delta;

    assign w_u = $signed({1'b0, i_cb}) - CHROMA_BIAS;
    assign w_v = $signed({1'b0, i_cr}) - CHROMA_BIAS;

    assign w_p_rv = w_v * COEF_RED_V;
    assign w_p_gu = w_u * COEF_GREEN_U;
    assign w_p_gv = w_v * COEF_GREEN_V;
    assign w_p_bu = w_u * COEF_BLUE_U;

    // arithmetic shift floors toward minus infinity
    assign w_s_rv = w_p_rv >>> 8;
    assign w_s_gu = w_p_gu >>> 8;
    assign w_s_gv = w_p_gv >>> 8;
    assign w_s_bu = w_p_bu >>> 8;

    always_comb begin
        n_delta.dr = {w_v[8], w_v} + w_s_rv[DELTA_W-1:0];
        n_delta.dg = {DELTA_W{1'b0}} - w_s_gu[DELTA_W-1:0] - w_s_gv[DELTA_W-1:0];
        n_delta.db = {w_u[8], w_u} + w_s_bu[DELTA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_delta <= n_delta;
        end
    end

    assign o_delta = r_delta;

endmodule

@@ hdl/yuyv_lane.sv @@
// One pixel lane: adds luma to the shared chroma offsets and saturates.
// Depends on yuyv_pkg.
module yuyv_lane
    import yuyv_pkg::*;
(
    input  logic [PIX_W-1:0]    i_luma,
    input  t_chroma_delta       i_delta,
    output t_rgb                o_rgb
);

    function automatic logic [PIX_W-1:0] f_clamp(input logic signed [SUM_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({3'b000, CHANNEL_MAX})) begin
            res = CHANNEL_MAX;
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

    logic signed [SUM_W-1:0] w_y;
    logic signed [SUM_W-1:0] w_r;
    logic signed [SUM_W-1:0] w_g;
    logic signed [SUM_W-1:0] w_b;

    assign w_y = $signed({3'b000, i_luma});
    assign w_r = w_y + {i_delta.dr[DELTA_W-1], i_delta.dr};
    assign w_g = w_y + {i_delta.dg[DELTA_W-1], i_delta.dg};
    assign w_b = w_y + {i_delta.db[DELTA_W-1], i_delta.db};

    always_comb begin
        o_rgb.r = f_clamp(w_r);
        o_rgb.g = f_clamp(w_g);
        o_rgb.b = f_clamp(w_b);
    end

endmodule

@@ hdl/yuyv_to_rgb24_converter.sv @@
// Top level of the YUYV to RGB24 converter: input stage, chroma stage,
// two pixel lanes and the output register. Depends on yuyv_pkg, yuyv_chroma, yuyv_lane.
//
// Converts one YUYV macropixel per request into two BT.601 full-range RGB24
// pixels. Fully pipelined: one request per cycle unless the master side stalls.
// The input stage registers both lumas and the shared chroma offsets, computed
// once; two luma lanes then add and saturate in parallel into the output
// register. Backpressure on the master side stalls the whole pipe;
// o_s_axis_tready follows o_m_axis_tvalid and i_m_axis_tready combinationally.
module yuyv_to_rgb24_converter
    import yuyv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] red_first, [15:8] green_first, [23:16] blue_first,
    // [31:24] red_second, [39:32] green_second, [47:40] blue_second
    output logic [47:0] o_m_axis_tdata
);

    logic               w_ce;
    logic               w_accept;
    logic               r_v1;
    logic               r_v2;
    logic [PIX_W-1:0]   r_y0;
    logic [PIX_W-1:0]   r_y1;
    t_chroma_delta      w_delta;
    t_rgb               w_px0;
    t_rgb               w_px1;
    t_rgb               r_px0;
    t_rgb               r_px1;

    assign w_ce     = !r_v2 || i_m_axis_tready;
    assign w_accept = i_s_axis_tvalid && w_ce;

    assign o_s_axis_tready = w_ce;
    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tdata  = {r_px1.b, r_px1.g, r_px1.r, r_px0.b, r_px0.g, r_px0.r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_ce) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_y0  <= i_s_axis_tdata[7:0];
            r_y1  <= i_s_axis_tdata[23:16];
            r_px0 <= w_px0;
            r_px1 <= w_px1;
        end
    end

    yuyv_chroma u_chroma (
        .i_clk   (i_clk),
        .i_en    (w_ce),
        .i_cb    (i_s_axis_tdata[15:8]),
        .i_cr    (i_s_axis_tdata[31:24]),
        .o_delta (w_delta)
    );

    yuyv_lane u_lane0 (
        .i_luma  (r_y0),
        .i_delta (w_delta),
        .o_rgb   (w_px0)
    );

    yuyv_lane u_lane1 (
        .i_luma  (r_y1),
        .i_delta (w_delta),
        .o_rgb   (w_px1)
    );

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_v1)
        else $error("accepted request not in stage one");

    a_stage1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_ce) |=> (r_v1 && $stable(r_y0) && $stable(r_y1)))
        else $error("stage one lost data during stall");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && w_ce) |=> o_m_axis_tvalid)
        else $error("stage one advanced without output");

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for yuyv_to_rgb24_converter: streams YUYV macropixels with random
// gaps on both sides and checks each RGB24 pair against an in-bench BT.601 predictor.
// Depends on yuyv_pkg and the converter RTL.
`timescale 1ns / 100ps

module testbench;
    import yuyv_pkg::*;

    localparam int BIAS      = 128;
    localparam int K_RED_V   = 104;
    localparam int K_GREEN_U = 89;
    localparam int K_GREEN_V = 183;
    localparam int K_BLUE_U  = 199;
    localparam int PIX_MAX   = 255;
    localparam int N_RANDOM  = 1250;
    localparam int CALM_TAIL = 150;

    // field order matches the tdata packing, lowest field last
    typedef struct packed {
        logic [7:0] chroma_red;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] luma_first;
    } macropixel_t;

    typedef struct packed {
        t_rgb second;
        t_rgb first;
    } rgb_pair_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;

    macropixel_t pending_pixels[$];
    rgb_pair_t   expected_rgb[$];
    int          n_errors = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          idle_pct = 0;
    int          cycle_cnt = 0;

    yuyv_to_rgb24_converter i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    function automatic logic [7:0] saturate8(int x);
        if (x < 0) return 8'd0;
        if (x > PIX_MAX) return 8'(PIX_MAX);
        return 8'(x);
    endfunction

    function automatic rgb_pair_t convert_macropixel(macropixel_t m);
        int u, v, dr, dg, db;
        rgb_pair_t p;
        u  = int'(m.chroma_blue) - BIAS;
        v  = int'(m.chroma_red) - BIAS;
        dr = v + ((v * K_RED_V) >>> 8);
        dg = -((u * K_GREEN_U) >>> 8) - ((v * K_GREEN_V) >>> 8);
        db = u + ((u * K_BLUE_U) >>> 8);
        p.first.r  = saturate8(int'(m.luma_first) + dr);
        p.first.g  = saturate8(int'(m.luma_first) + dg);
        p.first.b  = saturate8(int'(m.luma_first) + db);
        p.second.r = saturate8(int'(m.luma_second) + dr);
        p.second.g = saturate8(int'(m.luma_second) + dg);
        p.second.b = saturate8(int'(m.luma_second) + db);
        return p;
    endfunction

    function automatic void queue_pixel(int y0, int u, int y1, int v);
        macropixel_t m;
        m.luma_first  = 8'(y0);
        m.chroma_blue = 8'(u);
        m.luma_second = 8'(y1);
        m.chroma_red  = 8'(v);
        pending_pixels.push_back(m);
    endfunction

    // no new gaps are started once the tail of the run is reached
    function automatic logic calm();
        return (pending_pixels.size() < CALM_TAIL);
    endfunction

    task automatic check_channel(string name, logic [7:0] exp_val, logic [7:0] act_val);
        if (act_val !== exp_val) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
        end
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_rgb.push_back(convert_macropixel(i_s_axis_tdata));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= pending_pixels.pop_front();
                    if (!calm() && $urandom_range(99) < idle_pct)
                        src_gap = $urandom_range(1, 8);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    always @(posedge i_clk) begin
        rgb_pair_t exp_pair;
        rgb_pair_t act_pair;
        cycle_cnt++;
        if (cycle_cnt % 100 == 0) begin
            case ($urandom_range(2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 40;
            endcase
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                act_pair = o_m_axis_tdata;
                if (expected_rgb.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             o_m_axis_tdata);
                end else begin
                    exp_pair = expected_rgb.pop_front();
                    check_channel("red_first", exp_pair.first.r, act_pair.first.r);
                    check_channel("green_first", exp_pair.first.g, act_pair.first.g);
                    check_channel("blue_first", exp_pair.first.b, act_pair.first.b);
                    check_channel("red_second", exp_pair.second.r, act_pair.second.r);
                    check_channel("green_second", exp_pair.second.g, act_pair.second.g);
                    check_channel("blue_second", exp_pair.second.b, act_pair.second.b);
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (!calm() && $urandom_range(99) < idle_pct)
                    sink_gap = $urandom_range(1, 8);
            end
        end
    end

    initial begin
        int sel;
        // extremes, neutral chroma, saturation both ways, flooring of small negatives
        queue_pixel(0, 0, 0, 0);
        queue_pixel(255, 255, 255, 255);
        queue_pixel(0, 128, 255, 128);
        queue_pixel(255, 128, 0, 128);
        queue_pixel(128, 128, 128, 128);
        queue_pixel(255, 0, 0, 255);
        queue_pixel(0, 255, 255, 0);
        queue_pixel(255, 255, 0, 0);
        queue_pixel(0, 0, 255, 255);
        queue_pixel(128, 127, 128, 129);
        queue_pixel(128, 129, 128, 127);
        queue_pixel(16, 0, 235, 0);
        queue_pixel(235, 255, 16, 255);
        queue_pixel(200, 64, 50, 192);
        queue_pixel(1, 127, 254, 127);
        queue_pixel(254, 1, 1, 254);
        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(9);
            if (sel < 7)
                pending_pixels.push_back($urandom);
            else if (sel < 9)
                queue_pixel($urandom_range(255), $urandom_range(112, 144),
                            $urandom_range(255), $urandom_range(112, 144));
            else
                queue_pixel($urandom_range(1) * 255, $urandom_range(255),
                            $urandom_range(1) * 255, $urandom_range(255));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pixels.size() > 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (expected_rgb.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hdl/yuyv_pkg.sv
hdl/yuyv_chroma.sv
hdl/yuyv_lane.sv
hdl/yuyv_to_rgb24_converter.sv
verif/testbench.sv
